>>> sv/pfdrc_pkg.sv
// Shared types and constants for the deduplicating packet FIFO.
package pfdrc_pkg;

  localparam int DEPTH  = 64;
  localparam int NODE_W = 16;
  localparam int TIME_W = 31;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int CNT_W  = 7;

  // Request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_FWD   = 2'd1;
  localparam logic [1:0] REQ_COUNT = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [TIME_W-1:0] ts;
  } pkt_t;

  // Port controls for the packet store
  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
  } mem_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

>>> sv/pfdrc_mem.sv
// Packet store: one write port, one read port with registered read data.
module pfdrc_mem (
  input  logic              clk,
  input  pfdrc_pkg::mem_ctl_t ctl,
  input  pfdrc_pkg::pkt_t   wr_data,
  output pfdrc_pkg::pkt_t   rd_data
);
  import pfdrc_pkg::*;

  pkt_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule

>>> sv/packet_fifo_dedup_range_count.sv
// Scan: add and count read every stored entry, forward reads only the oldest, an unknown
//   request none; one store read per cycle.
// Flow: one request at a time; a new request is taken once the previous
//   result sits in the output register.
// Reset: rst (synchronous) empties the FIFO, sets capacity_limit to 64 and drops
//   any pending result; store contents are left as they are.
module packet_fifo_dedup_range_count (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_write,
  input  logic [6:0]                cfg_data,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                req_type,
  input  logic [pfdrc_pkg::NODE_W-1:0] source,
  input  logic [pfdrc_pkg::NODE_W-1:0] destination,
  input  logic [pfdrc_pkg::TIME_W-1:0] timestamp,
  input  logic [pfdrc_pkg::TIME_W-1:0] start_time,
  input  logic [pfdrc_pkg::TIME_W-1:0] end_time,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      accepted,
  output logic                      packet_valid,
  output logic [pfdrc_pkg::NODE_W-1:0] out_source,
  output logic [pfdrc_pkg::NODE_W-1:0] out_destination,
  output logic [pfdrc_pkg::TIME_W-1:0] out_timestamp,
  output logic [pfdrc_pkg::CNT_W-1:0]  match_count
);
  import pfdrc_pkg::*;

  localparam logic [OCC_W-1:0] LIM_MAX   = OCC_W'(DEPTH);
  localparam logic [CNT_W-1:0] COUNT_SAT = '1;

  state_t state, state_next;

  logic [6:0]       capacity_limit;
  logic [PTR_W-1:0] head;
  logic [OCC_W-1:0] occ;

  // latched request
  logic [1:0]        req;
  pkt_t              req_pkt;
  logic [TIME_W-1:0] lo_t, hi_t;
  logic [OCC_W-1:0]  n_reads;

  // scan state
  logic [OCC_W-1:0]  issue_cnt;
  logic              rd_pend;
  logic              dup;
  logic [CNT_W-1:0]  cnt;
  pkt_t              fwd_pkt;

  mem_ctl_t ctl;
  pkt_t     rd_data;

  logic in_xfer, out_free, scan_done, commit, issue;
  logic [OCC_W-1:0] lim;
  logic evict;
  logic hit_dup, hit_cnt;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !(out_valid && out_stall);
  assign scan_done = (issue_cnt == n_reads) && !rd_pend;
  assign issue    = (state == ST_SCAN) && (issue_cnt != n_reads);

  // effective limit: 0 acts as 1, above DEPTH acts as DEPTH
  always_comb begin
    if (capacity_limit == '0) begin
      lim = OCC_W'(1);
    end else if (OCC_W'(capacity_limit) > LIM_MAX) begin
      lim = LIM_MAX;
    end else begin
      lim = OCC_W'(capacity_limit);
    end
  end
  assign evict = (occ >= lim);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_xfer) state_next = ST_SCAN;
      ST_SCAN:   if (scan_done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
    commit   = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= 7'd64;
    end else if (cfg_write) begin
      capacity_limit <= cfg_data;
    end
  end

  // request capture; read count depends on request kind
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req         <= req_type;
      req_pkt.src <= source;
      req_pkt.dst <= destination;
      req_pkt.ts  <= timestamp;
      lo_t        <= start_time;
      hi_t        <= end_time;
      case (req_type)
        REQ_ADD, REQ_COUNT: n_reads <= occ;
        REQ_FWD:            n_reads <= (occ != '0) ? OCC_W'(1) : '0;
        default:            n_reads <= '0;
      endcase
    end
  end

  // store controls; the write lands only after the scan has drained, so
  // the next request's reads always see it
  always_comb begin
    ctl.rd_en   = issue;
    ctl.rd_addr = head + issue_cnt[PTR_W-1:0];
    ctl.wr_en   = commit && (req == REQ_ADD) && !dup;
    ctl.wr_addr = head + occ[PTR_W-1:0];
  end

  pfdrc_mem u_mem (
    .clk     (clk),
    .ctl     (ctl),
    .wr_data (req_pkt),
    .rd_data (rd_data)
  );

  // compare stage on returned data
  assign hit_dup = (rd_data.src == req_pkt.src) && (rd_data.dst == req_pkt.dst) &&
                   (rd_data.ts == req_pkt.ts);
  assign hit_cnt = (rd_data.dst == req_pkt.dst) && (rd_data.ts >= lo_t) &&
                   (rd_data.ts <= hi_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      issue_cnt <= '0;
      dup       <= 1'b0;
      cnt       <= '0;
      fwd_pkt   <= '0;
    end else begin
      if (issue) begin
        issue_cnt <= issue_cnt + OCC_W'(1);
      end
      if (rd_pend) begin
        if (hit_dup) dup <= 1'b1;
        if (hit_cnt && (cnt != COUNT_SAT)) cnt <= cnt + CNT_W'(1);
        fwd_pkt <= rd_data;
      end
    end
  end

  // FIFO pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
    end else if (commit) begin
      case (req)
        REQ_ADD: begin
          if (!dup) begin
            if (evict) begin
              head <= head + PTR_W'(1);
            end else begin
              occ <= occ + OCC_W'(1);
            end
          end
        end
        REQ_FWD: begin
          if (occ != '0) begin
            head <= head + PTR_W'(1);
            occ  <= occ - OCC_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      accepted        <= 1'b0;
      packet_valid    <= 1'b0;
      out_source      <= '0;
      out_destination <= '0;
      out_timestamp   <= '0;
      match_count     <= '0;
      case (req)
        REQ_ADD: accepted <= !dup;
        REQ_FWD: begin
          if (n_reads != '0) begin
            packet_valid    <= 1'b1;
            out_source      <= fwd_pkt.src;
            out_destination <= fwd_pkt.dst;
            out_timestamp   <= fwd_pkt.ts;
          end
        end
        REQ_COUNT: match_count <= cnt;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/pfdrc_checker.sv
// Port-level checks for the deduplicating packet FIFO, bound to the top level.
module pfdrc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      accepted,
  input logic                      packet_valid,
  input logic [pfdrc_pkg::NODE_W-1:0] out_source,
  input logic [pfdrc_pkg::NODE_W-1:0] out_destination,
  input logic [pfdrc_pkg::TIME_W-1:0] out_timestamp,
  input logic [pfdrc_pkg::CNT_W-1:0]  match_count
);
  import pfdrc_pkg::*;

  // one request in flight: busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still in flight");

  // a result carries fields of at most one request kind
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && packet_valid) && !(accepted && match_count != '0) &&
                  !(packet_valid && match_count != '0))
    else $error("result carries fields of more than one request kind");

  // no packet, no packet fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !packet_valid |->
      out_source == '0 && out_destination == '0 && out_timestamp == '0)
    else $error("packet fields set without a forwarded packet");

  // a count can never exceed the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> match_count <= CNT_W'(DEPTH))
    else $error("match count above store depth");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(match_count) &&
                               $stable(out_timestamp) && $stable(accepted))
    else $error("stalled result changed");

endmodule

bind packet_fifo_dedup_range_count pfdrc_checker u_pfdrc_checker (.*);

>>> test/tb_packet_fifo_dedup_range_count.sv
// Self-checking testbench for the deduplicating packet FIFO with windowed count.
`timescale 1ns / 100ps

module tb_packet_fifo_dedup_range_count;
  import pfdrc_pkg::*;

  // Request code with no meaning; the block must answer it with all zeros
  localparam logic [1:0] REQ_OTHER = 2'd3;
  localparam logic [NODE_W-1:0] NODE_MAX = '1;
  localparam logic [TIME_W-1:0] TS_MAX = '1;
  localparam logic [CNT_W-1:0] COUNT_SAT = '1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RECENT_KEEP = 16;

  typedef struct packed {
    logic             accepted;
    logic             packet_valid;
    pkt_t             pkt;
    logic [CNT_W-1:0] count;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [6:0]        cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        req_type = '0;
  logic [NODE_W-1:0] source = '0;
  logic [NODE_W-1:0] destination = '0;
  logic [TIME_W-1:0] timestamp = '0;
  logic [TIME_W-1:0] start_time = '0;
  logic [TIME_W-1:0] end_time = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              accepted;
  logic              packet_valid;
  logic [NODE_W-1:0] out_source;
  logic [NODE_W-1:0] out_destination;
  logic [TIME_W-1:0] out_timestamp;
  logic [CNT_W-1:0]  match_count;

  // Mirror of the packet store, oldest entry at fifo_head
  pkt_t       fifo_pkt [DEPTH];
  int         fifo_head = 0;
  int         fifo_count = 0;
  logic [6:0] fifo_limit = 7'd64;

  reply_t     expected_replies[$];
  pkt_t       recent_pkts[$];
  logic [TIME_W-1:0] ts_clock = '0;
  int send_idle_pct = 27;
  int recv_idle_pct = 69;
  int error_count = 0;
  int cycle_count = 0;
  int results_checked = 0;
  int req_totals[4] = '{default: 0};

  packet_fifo_dedup_range_count uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .source         (source),
    .destination    (destination),
    .timestamp      (timestamp),
    .start_time     (start_time),
    .end_time       (end_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .accepted       (accepted),
    .packet_valid   (packet_valid),
    .out_source     (out_source),
    .out_destination(out_destination),
    .out_timestamp  (out_timestamp),
    .match_count    (match_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Expected reply for one request; updates the mirrored store
  function automatic reply_t predict_reply(input logic [1:0] kind,
                                           input logic [NODE_W-1:0] src,
                                           input logic [NODE_W-1:0] dst,
                                           input logic [TIME_W-1:0] ts,
                                           input logic [TIME_W-1:0] lo,
                                           input logic [TIME_W-1:0] hi);
    reply_t r;
    int     limit_eff;
    int     idx;
    bit     dup;
    r = '0;
    dup = 1'b0;
    limit_eff = (fifo_limit == 0) ? 1 : (fifo_limit > DEPTH) ? DEPTH : int'(fifo_limit);
    case (kind)
      REQ_ADD: begin
        for (int k = 0; k < fifo_count; k++) begin
          idx = (fifo_head + k) % DEPTH;
          if (fifo_pkt[idx].src == src && fifo_pkt[idx].dst == dst && fifo_pkt[idx].ts == ts)
            dup = 1'b1;
        end
        if (!dup) begin
          // at the limit: evict one, then append
          if (fifo_count >= limit_eff && fifo_count > 0) begin
            fifo_head = (fifo_head + 1) % DEPTH;
            fifo_count--;
          end
          idx = (fifo_head + fifo_count) % DEPTH;
          fifo_pkt[idx].src = src;
          fifo_pkt[idx].dst = dst;
          fifo_pkt[idx].ts = ts;
          fifo_count++;
          r.accepted = 1'b1;
        end
      end
      REQ_FWD: begin
        if (fifo_count != 0) begin
          r.packet_valid = 1'b1;
          r.pkt = fifo_pkt[fifo_head];
          fifo_head = (fifo_head + 1) % DEPTH;
          fifo_count--;
        end
      end
      REQ_COUNT: begin
        for (int k = 0; k < fifo_count; k++) begin
          idx = (fifo_head + k) % DEPTH;
          if (fifo_pkt[idx].dst == dst && fifo_pkt[idx].ts >= lo && fifo_pkt[idx].ts <= hi &&
              r.count != COUNT_SAT)
            r.count++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Mostly a few recurring node ids so duplicates and count hits happen
  function automatic logic [NODE_W-1:0] pick_node();
    logic [NODE_W-1:0] pool [4];
    pool = '{16'h0000, 16'h0001, 16'hFFFF, 16'h5A5A};
    if ($urandom_range(99) < 70)
      return pool[$urandom_range(3)];
    return NODE_W'($urandom);
  endfunction

  // One request transfer; valid stays high afterwards until the next call decides
  task automatic send_request(input logic [1:0] kind, input logic [NODE_W-1:0] src,
                              input logic [NODE_W-1:0] dst, input logic [TIME_W-1:0] ts,
                              input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    source      <= src;
    destination <= dst;
    timestamp   <= ts;
    start_time  <= lo;
    end_time    <= hi;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_replies.push_back(predict_reply(kind, src, dst, ts, lo, hi));
    req_totals[kind]++;
  endtask

  // Hold off until every outstanding reply is back, then let the block settle
  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] value);
    drain_results(SETTLE_CYCLES);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    fifo_limit = value;
  endtask

  // Random request: well-formed traffic on a rising clock, with some noise
  task automatic issue_random_request();
    logic [1:0]        kind;
    pkt_t              p;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    int                roll;
    int                shape;
    roll  = $urandom_range(99);
    shape = $urandom_range(99);
    p.src = NODE_W'($urandom);
    p.dst = NODE_W'($urandom);
    p.ts  = TIME_W'($urandom);
    lo    = TIME_W'($urandom);
    hi    = TIME_W'($urandom);
    if (roll < 52) begin
      kind = REQ_ADD;
      if (recent_pkts.size() != 0 && shape < 15) begin
        p = recent_pkts[$urandom_range(recent_pkts.size() - 1)];
      end else begin
        p.src = pick_node();
        p.dst = pick_node();
        if (shape >= 20) begin
          ts_clock = ts_clock + TIME_W'($urandom_range(3));
          p.ts = ts_clock;
        end
      end
      recent_pkts.push_back(p);
      if (recent_pkts.size() > RECENT_KEEP) void'(recent_pkts.pop_front());
    end else if (roll < 72) begin
      kind = REQ_FWD;
    end else if (roll < 97) begin
      kind = REQ_COUNT;
      p.dst = pick_node();
      if (shape >= 10) begin
        lo = (ts_clock > 40) ? ts_clock - TIME_W'($urandom_range(40)) : '0;
        hi = lo + TIME_W'($urandom_range(40));
      end
      if (shape >= 10 && shape < 20) begin
        lo = '0;
        hi = TS_MAX;
      end else if (shape >= 20 && shape < 30) begin
        // reversed window
        hi = lo;
        lo = lo + TIME_W'($urandom_range(1, 10));
      end
    end else begin
      kind = REQ_OTHER;
    end
    send_request(kind, p.src, p.dst, p.ts, lo, hi);
  endtask

  // Extremes of every field, every request code, duplicates and empty cases
  task automatic test_basic_requests();
    send_request(REQ_FWD, 16'h1234, 16'h4321, 31'd5, '0, TS_MAX);
    send_request(REQ_COUNT, '0, '0, '0, '0, TS_MAX);
    send_request(REQ_OTHER, NODE_MAX, NODE_MAX, TS_MAX, TS_MAX, TS_MAX);
    send_request(REQ_ADD, '0, '0, '0, '0, '0);
    send_request(REQ_ADD, NODE_MAX, NODE_MAX, TS_MAX, TS_MAX, TS_MAX);
    send_request(REQ_ADD, '0, '0, '0, TS_MAX, '0);
    send_request(REQ_COUNT, '0, NODE_MAX, '0, '0, TS_MAX);
    send_request(REQ_COUNT, NODE_MAX, '0, TS_MAX, 31'd5, 31'd2);
    // older timestamp after the maximum one
    send_request(REQ_ADD, 16'h1234, '0, 31'd10, '0, '0);
    send_request(REQ_COUNT, '0, '0, '0, '0, 31'd10);
    send_request(REQ_FWD, '0, '0, '0, '0, '0);
    send_request(REQ_FWD, NODE_MAX, NODE_MAX, TS_MAX, TS_MAX, TS_MAX);
  endtask

  // Eviction at the limit, duplicate of the oldest, limit below occupancy, 0 and 1
  task automatic test_capacity_edges();
    write_capacity(7'd2);
    send_request(REQ_ADD, 16'h00A1, 16'h0010, 31'd20, '0, '0);
    send_request(REQ_ADD, 16'h00A2, 16'h0010, 31'd21, '0, '0);
    send_request(REQ_ADD, 16'h00A1, 16'h0010, 31'd20, '0, '0);
    send_request(REQ_FWD, '0, '0, '0, '0, '0);
    write_capacity(7'd64);
    send_request(REQ_ADD, 16'h00B1, 16'h0020, 31'd30, '0, '0);
    send_request(REQ_ADD, 16'h00B2, 16'h0020, 31'd31, '0, '0);
    send_request(REQ_ADD, 16'h00B3, 16'h0020, 31'd32, '0, '0);
    write_capacity(7'd1);
    send_request(REQ_ADD, 16'h00C1, 16'h0030, 31'd40, '0, '0);
    write_capacity(7'd0);
    send_request(REQ_ADD, 16'h00C2, 16'h0030, 31'd41, '0, '0);
    repeat (4) send_request(REQ_FWD, '0, '0, '0, '0, '0);
  endtask

  task automatic test_random_traffic(input int s_pct, input int r_pct, input logic [6:0] limit,
                                     input int n);
    write_capacity(limit);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      // halfway: let the store answer everything before going on
      if (i == n / 2) drain_results(1);
      issue_random_request();
    end
  endtask

  // Fill past the full store with one destination, then count and drain a little
  task automatic test_full_store();
    logic [NODE_W-1:0] dst;
    dst = pick_node();
    write_capacity(7'd127);
    for (int i = 0; i < 70; i++) begin
      ts_clock = ts_clock + TIME_W'(1);
      send_request(REQ_ADD, NODE_W'($urandom), dst, ts_clock, TIME_W'($urandom),
                   TIME_W'($urandom));
    end
    send_request(REQ_COUNT, NODE_W'($urandom), dst, TIME_W'($urandom), '0, TS_MAX);
    send_request(REQ_COUNT, NODE_W'($urandom), dst, TIME_W'($urandom),
                 ts_clock - TIME_W'(9), ts_clock);
    repeat (6) send_request(REQ_FWD, NODE_W'($urandom), NODE_W'($urandom), TIME_W'($urandom),
                            TIME_W'($urandom), TIME_W'($urandom));
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    reply_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_replies.size() == 0) begin
        $error("result transfer with no request outstanding");
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        results_checked++;
        check_field("accepted", 32'(want.accepted), 32'(accepted));
        check_field("packet_valid", 32'(want.packet_valid), 32'(packet_valid));
        check_field("out_source", 32'(want.pkt.src), 32'(out_source));
        check_field("out_destination", 32'(want.pkt.dst), 32'(out_destination));
        check_field("out_timestamp", 32'(want.pkt.ts), 32'(out_timestamp));
        check_field("match_count", 32'(want.count), 32'(match_count));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_replies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    ts_clock = TIME_W'($urandom_range(1000));
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_basic_requests();
    test_capacity_edges();
    test_random_traffic(27, 69, 7'd3, 250);
    test_random_traffic(69, 27, 7'd100, 300);
    test_random_traffic(0, 0, 7'd64, 280);
    test_full_store();
    drain_results(8);
    $display("Checked %0d results: %0d adds, %0d forwards, %0d counts, %0d unknown codes.",
             results_checked, req_totals[REQ_ADD], req_totals[REQ_FWD], req_totals[REQ_COUNT],
             req_totals[REQ_OTHER]);
    $display("Capacity 0, 1, 2, 3, 64, 100 and 127 exercised under three stall patterns.");
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
